>>> hdl/unsorted_id_table_top_assert.svh
// Assertion macros shared by the ID table modules.
// Each expects clk_i and rst_ni in scope.
`ifndef UNSORTED_ID_TABLE_TOP_ASSERT_SVH
`define UNSORTED_ID_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define UIT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UIT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/uit_pkg.sv
// ----------------------------------------------------------------------------
// uit_pkg
// Types and codes shared by the ID table controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package uit_pkg;

  // Opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_MISS  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_LAST,
    S_SWAP,
    S_RD_WAIT,
    S_FIN
  } state_e;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_PTR,
    RD_LAST,
    RD_IDX
  } rd_sel_e;

  typedef struct packed {
    logic       load;      // capture input word, clear scan state
    logic       scan;      // step the search pointer
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_ins;    // append id at the back
    logic       wr_swap;   // move last entry into matched slot
    logic       st_we;
    logic [1:0] st_code;
    logic       rv_cap;    // capture read data as result value
    logic       res_load;  // load output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       cnt_full;
    logic       idx_ok;
    logic       match;
    logic       scan_done;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/unsorted_id_table_top.sv
// ----------------------------------------------------------------------------
// unsorted_id_table_top
// Unordered table of 32-bit IDs: append, swap-delete by value, indexed read.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  in        in_valid_i / in_stall_o    opcode_i, id_value_i, read_index_i
//  out       out_valid_o / out_stall_i  status_o, entry_count_o, is_full_o,
//                                       is_empty_o, read_value_o
//
//  Delete searches the store, reading one stored entry per cycle through the
//  single memory read port.
//  One word in flight; a new word is taken while the previous result waits,
//  and its own result then holds until the output register frees up.
//  Reset clears the fill count, the search check flag and the output valid flag;
//  the store itself is never cleared.
`default_nettype none

module unsorted_id_table_top #(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [31:0] id_value_i,
  input  wire logic [6:0]         read_index_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [1:0]         status_o,
  output      logic [7:0]         entry_count_o,
  output      logic               is_full_o,
  output      logic               is_empty_o,
  output      logic signed [31:0] read_value_o
);

  uit_pkg::cmd_t  cmd;
  uit_pkg::stat_t stat;

  uit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  uit_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .id_value_i    (id_value_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o),
    .read_value_o  (read_value_o)
  );

endmodule

`default_nettype wire

>>> hdl/uit_datapath.sv
// ----------------------------------------------------------------------------
// uit_datapath
// ID store, fill count, search pointer and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unsorted_id_table_top_assert.svh"

module uit_datapath #(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire uit_pkg::cmd_t      cmd_i,
  output      uit_pkg::stat_t     stat_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [31:0] id_value_i,
  input  wire logic [6:0]         read_index_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [1:0]         status_o,
  output      logic [7:0]         entry_count_o,
  output      logic               is_full_o,
  output      logic               is_empty_o,
  output      logic signed [31:0] read_value_o
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam int OW   = (CW > 8) ? CW : 8;

  logic [31:0]     mem_q [CAPACITY];
  logic [1:0]      op_q;
  logic [31:0]     id_q;
  logic [6:0]      idx_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   ptr_q;
  logic [CW-1:0]   last_c;
  logic [AW-1:0]   pos_q;
  logic [AW-1:0]   chk_addr_q;
  logic [AW-1:0]   rd_addr_c;
  logic [AW-1:0]   wr_addr_c;
  logic [AW-1:0]   idx_addr_c;
  logic [CMPW-1:0] idx_w;
  logic [CMPW-1:0] cnt_w;
  logic [OW-1:0]   cnt_ow;
  logic            chk_q;
  logic [31:0]     rd_data_q;
  logic [31:0]     rv_q;
  logic [31:0]     wr_data_c;
  logic [1:0]      st_q;
  logic            ptr_end;
  logic            scan_rd;
  logic            rd_en_c;
  logic            wr_en_c;
  logic            match_c;
  logic            out_valid_q;
  logic            out_free_c;
  logic            cnt_full_c;
  logic [1:0]      out_status_q;
  logic [7:0]      out_cnt_q;
  logic            out_full_q;
  logic            out_empty_q;
  logic [31:0]     out_val_q;

  assign idx_w      = CMPW'(idx_q);
  assign cnt_w      = CMPW'(cnt_q);
  assign idx_addr_c = idx_w[AW-1:0];
  assign cnt_ow     = OW'(cnt_q);
  assign last_c     = cnt_q - CW'(1);
  assign ptr_end    = (ptr_q == cnt_q);
  assign scan_rd    = cmd_i.scan && !ptr_end;
  assign rd_en_c    = cmd_i.rd_en || scan_rd;
  assign wr_en_c    = cmd_i.wr_ins || cmd_i.wr_swap;
  assign wr_addr_c  = cmd_i.wr_ins ? cnt_q[AW-1:0] : pos_q;
  assign wr_data_c  = cmd_i.wr_ins ? id_q : rd_data_q;
  assign match_c    = chk_q && (rd_data_q == id_q);
  assign out_free_c = !out_valid_q || !out_stall_i;
  assign cnt_full_c = (cnt_q == CW'(CAPACITY));

  always_comb begin
    case (cmd_i.rd_sel)
      uit_pkg::RD_LAST: rd_addr_c = last_c[AW-1:0];
      uit_pkg::RD_IDX:  rd_addr_c = idx_addr_c;
      default:          rd_addr_c = ptr_q[AW-1:0];
    endcase
  end

  always_comb begin
    stat_o.op        = op_q;
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.cnt_full  = cnt_full_c;
    stat_o.idx_ok    = (idx_w < cnt_w);
    stat_o.match     = match_c;
    stat_o.scan_done = ptr_end && !chk_q;
    stat_o.out_free  = out_free_c;
  end

  // Single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_c) begin
      mem_q[wr_addr_c] <= wr_data_c;
    end
    if (rd_en_c) begin
      rd_data_q <= mem_q[rd_addr_c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_ins) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.wr_swap) begin
        cnt_q <= last_c;
      end
      chk_q <= scan_rd;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      id_q  <= id_value_i;
      idx_q <= read_index_i;
      ptr_q <= '0;
      st_q  <= uit_pkg::STS_OK;
      rv_q  <= '0;
    end
    if (cmd_i.scan) begin
      chk_addr_q <= ptr_q[AW-1:0];
      if (scan_rd) begin
        ptr_q <= ptr_q + CW'(1);
      end
      // first match wins; controller leaves the scan on it
      if (match_c) begin
        pos_q <= chk_addr_q;
      end
    end
    if (cmd_i.st_we) begin
      st_q <= cmd_i.st_code;
    end
    if (cmd_i.rv_cap) begin
      rv_q <= rd_data_q;
    end
    if (cmd_i.res_load) begin
      out_status_q <= st_q;
      out_cnt_q    <= cnt_ow[7:0];
      out_full_q   <= cnt_full_c;
      out_empty_q  <= (cnt_q == '0);
      out_val_q    <= rv_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_cnt_q;
  assign is_full_o     = out_full_q;
  assign is_empty_o    = out_empty_q;
  assign read_value_o  = out_val_q;

  `UIT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(CAPACITY), "fill count beyond capacity")
  `UIT_ASSERT_IMP(a_ins_room, cmd_i.wr_ins, !cnt_full_c, "append into a full table")
  `UIT_ASSERT_NXT(a_swap_dec, cmd_i.wr_swap, cnt_q == $past(last_c), "swap did not shrink count")

endmodule

`default_nettype wire

>>> hdl/uit_ctrl.sv
// ----------------------------------------------------------------------------
// uit_ctrl
// Sequencer for insert, delete-by-value and indexed read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unsorted_id_table_top_assert.svh"

module uit_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_stall_o,
  input  wire uit_pkg::stat_t stat_i,
  output      uit_pkg::cmd_t  cmd_o
);

  uit_pkg::state_e state_q;
  uit_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uit_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      uit_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = uit_pkg::S_EXEC;
        end
      end
      uit_pkg::S_EXEC: begin
        state_d = uit_pkg::S_FIN;
        case (stat_i.op)
          uit_pkg::OP_INSERT: begin
            if (stat_i.cnt_full) begin
              cmd_o.st_we   = 1'b1;
              cmd_o.st_code = uit_pkg::STS_FULL;
            end else begin
              cmd_o.wr_ins = 1'b1;
            end
          end
          uit_pkg::OP_DELETE: begin
            if (stat_i.cnt_zero) begin
              cmd_o.st_we   = 1'b1;
              cmd_o.st_code = uit_pkg::STS_EMPTY;
            end else begin
              state_d = uit_pkg::S_SCAN;
            end
          end
          uit_pkg::OP_READ: begin
            if (stat_i.idx_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = uit_pkg::RD_IDX;
              state_d      = uit_pkg::S_RD_WAIT;
            end else begin
              cmd_o.st_we   = 1'b1;
              cmd_o.st_code = uit_pkg::STS_MISS;
            end
          end
          default: ;  // unused opcode: no change, status ok
        endcase
      end
      uit_pkg::S_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.rd_sel = uit_pkg::RD_PTR;
        if (stat_i.match) begin
          state_d = uit_pkg::S_LAST;
        end else if (stat_i.scan_done) begin
          cmd_o.st_we   = 1'b1;
          cmd_o.st_code = uit_pkg::STS_MISS;
          state_d       = uit_pkg::S_FIN;
        end
      end
      uit_pkg::S_LAST: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = uit_pkg::RD_LAST;
        state_d      = uit_pkg::S_SWAP;
      end
      uit_pkg::S_SWAP: begin
        cmd_o.wr_swap = 1'b1;
        state_d       = uit_pkg::S_FIN;
      end
      uit_pkg::S_RD_WAIT: begin
        cmd_o.rv_cap = 1'b1;
        state_d      = uit_pkg::S_FIN;
      end
      uit_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = uit_pkg::S_IDLE;
        end
      end
      default: state_d = uit_pkg::S_IDLE;
    endcase
  end

  `UIT_ASSERT_IMP(a_res_free, cmd_o.res_load, stat_i.out_free, "result word overwritten")
  `UIT_ASSERT_NXT(a_match_last, (state_q == uit_pkg::S_SCAN) && stat_i.match, state_q == uit_pkg::S_LAST, "match not followed by last-entry read")
  `UIT_ASSERT_IMP(a_swap_after_last, cmd_o.wr_swap, $past(state_q) == uit_pkg::S_LAST, "swap without last-entry read")

endmodule

`default_nettype wire
